// ===== src/spm_pkg.sv =====
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants for the sensor poll master: item, result and
// configuration bundles, event codes and CRC-16 constants.
// ----------------------------------------------------------------------------
package spm_pkg;

  // event codes carried by the op field
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_REPLY  = 2'd1,
    OP_MAP_WR = 2'd2
  } op_e;

  // configuration register indexes
  localparam logic CFG_RESPONSE_TIMEOUT = 1'b0;
  localparam logic CFG_MAX_RETRIES      = 1'b1;

  // configuration reset values
  localparam logic [15:0] TIMEOUT_RST = 16'd300;
  localparam logic [3:0]  RETRIES_RST = 4'd3;

  // CRC-16 (reflected) parameters
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // request frame bytes and polled address range
  localparam logic [7:0] REQ_FUNC   = 8'h01;
  localparam logic [7:0] REQ_DATA   = 8'h00;
  localparam logic [7:0] ADDR_FIRST = 8'd1;
  localparam logic [7:0] ADDR_LAST  = 8'd254;

  // saturation limits
  localparam logic [15:0] CNT16_MAX = 16'hFFFF;
  localparam logic [3:0]  RETRY_MAX = 4'hF;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_addr;
    logic [7:0] rx_status;
    logic [7:0] rx_error;
    logic [7:0] rx_crc_low;
    logic [7:0] rx_crc_high;
    logic [7:0] table_addr;
    logic       table_enable;
  } item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_addr;
    logic [15:0] tx_crc;
    logic        abort_receive;
    logic        wire_fault_set;
    logic [7:0]  fault_addr;
    logic        reply_ok;
    logic        reply_crc_error;
    logic [15:0] fire_count;
  } result_t;

  typedef struct packed {
    logic [15:0] response_timeout;
    logic [3:0]  max_retries;
  } cfg_t;

endpackage

// ===== src/sensor_poll_master_core.sv =====
// ----------------------------------------------------------------------------
// sensor_poll_master_core
// Polling master for a multi-drop sensor bus with CRC-16 framed requests and
// reply checks, timeout retries and wire fault marking.
// ----------------------------------------------------------------------------
// path: an input transfer reaches result valid through the input register,
//   step logic and result register
// throughput: one item per cycle; the result register drains while the next
//   item steps, so the block stalls only when the output side stalls
// reset: asynchronous, active low; enable map, counters and poll state clear,
//   registers return to timeout 300 and 3 retries
module sensor_poll_master_core #(
  parameter int ADDR_SPACE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  rx_addr_i,
  input  logic [7:0]  rx_status_i,
  input  logic [7:0]  rx_error_i,
  input  logic [7:0]  rx_crc_low_i,
  input  logic [7:0]  rx_crc_high_i,
  input  logic [7:0]  table_addr_i,
  input  logic        table_enable_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_addr_o,
  output logic [15:0] tx_crc_o,
  output logic        abort_receive_o,
  output logic        wire_fault_set_o,
  output logic [7:0]  fault_addr_o,
  output logic        reply_ok_o,
  output logic        reply_crc_error_o,
  output logic [15:0] fire_count_o
);

  spm_pkg::cfg_t    cfg_q;
  spm_pkg::item_t   item_q;
  spm_pkg::result_t res;
  spm_pkg::result_t res_q;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             out_free;
  logic             step;

  // handshake between stages
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || step;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.response_timeout <= spm_pkg::TIMEOUT_RST;
      cfg_q.max_retries      <= spm_pkg::RETRIES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spm_pkg::CFG_RESPONSE_TIMEOUT: cfg_q.response_timeout <= cfg_wdata_i;
        spm_pkg::CFG_MAX_RETRIES:      cfg_q.max_retries      <= cfg_wdata_i[3:0];
        default: begin
        end
      endcase
    end
  end

  // input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.op           <= op_i;
      item_q.rx_addr      <= rx_addr_i;
      item_q.rx_status    <= rx_status_i;
      item_q.rx_error     <= rx_error_i;
      item_q.rx_crc_low   <= rx_crc_low_i;
      item_q.rx_crc_high  <= rx_crc_high_i;
      item_q.table_addr   <= table_addr_i;
      item_q.table_enable <= table_enable_i;
    end
  end

  // poll state and step logic
  spm_ctrl #(
    .ADDR_SPACE (ADDR_SPACE)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // result stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step;
    end
  end

  // result stage payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign tx_valid_o        = res_q.tx_valid;
  assign tx_addr_o         = res_q.tx_addr;
  assign tx_crc_o          = res_q.tx_crc;
  assign abort_receive_o   = res_q.abort_receive;
  assign wire_fault_set_o  = res_q.wire_fault_set;
  assign fault_addr_o      = res_q.fault_addr;
  assign reply_ok_o        = res_q.reply_ok;
  assign reply_crc_error_o = res_q.reply_crc_error;
  assign fire_count_o      = res_q.fire_count;

endmodule

// ===== src/spm_crc3.sv =====
// ----------------------------------------------------------------------------
// spm_crc3
// CRC-16/MODBUS over a three-byte frame, first byte first, as a flat XOR
// network.
// ----------------------------------------------------------------------------
module spm_crc3 (
  input  logic [7:0]  byte0_i,
  input  logic [7:0]  byte1_i,
  input  logic [7:0]  byte2_i,
  output logic [15:0] crc_o
);

  logic [2:0][7:0] frame;
  logic [15:0]     crc;

  assign frame = {byte2_i, byte1_i, byte0_i};

  // bitwise reflected crc, unrolled
  always_comb begin
    crc = spm_pkg::CRC_INIT;
    for (int i = 0; i < 3; i++) begin
      crc = crc ^ {8'h00, frame[i]};
      for (int k = 0; k < 8; k++) begin
        if (crc[0]) begin
          crc = (crc >> 1) ^ spm_pkg::CRC_POLY;
        end else begin
          crc = crc >> 1;
        end
      end
    end
  end

  assign crc_o = crc;

endmodule

// ===== src/spm_ctrl.sv =====
// ----------------------------------------------------------------------------
// spm_ctrl
// Polling state and the per-item step: event, send, timeout and reply
// handling, all in one pass. State moves when step_i is high.
// ----------------------------------------------------------------------------
module spm_ctrl #(
  parameter int ADDR_SPACE = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  spm_pkg::item_t  item_i,
  input  spm_pkg::cfg_t   cfg_i,
  output spm_pkg::result_t res_o
);

  localparam int          IdxW     = $clog2(ADDR_SPACE);
  localparam logic [8:0]  SpaceLim = 9'(ADDR_SPACE);

  // state
  logic [7:0]            cur_addr_q, cur_addr_d;
  logic                  send_ready_q, send_ready_d;
  logic                  awaiting_q, awaiting_d;
  logic [15:0]           wait_ticks_q, wait_ticks_d;
  logic [3:0]            retry_q, retry_d;
  logic [ADDR_SPACE-1:0] en_map_q, en_map_d;
  logic [15:0]           fire_total_q, fire_total_d;

  logic [7:0]  norm_addr;
  logic [15:0] tx_crc;
  logic [15:0] rx_crc_calc;
  logic [15:0] rx_crc;
  logic        received;
  logic        cur_en;
  spm_pkg::result_t res;

  // normalized poll address, used only when a send is due
  assign norm_addr = (cur_addr_q < spm_pkg::ADDR_FIRST || cur_addr_q > spm_pkg::ADDR_LAST)
                     ? spm_pkg::ADDR_FIRST : cur_addr_q;

  assign rx_crc = {item_i.rx_crc_high, item_i.rx_crc_low};

  // request frame checksum
  spm_crc3 u_tx_crc (
    .byte0_i (norm_addr),
    .byte1_i (spm_pkg::REQ_FUNC),
    .byte2_i (spm_pkg::REQ_DATA),
    .crc_o   (tx_crc)
  );

  // reply frame checksum
  spm_crc3 u_rx_crc (
    .byte0_i (item_i.rx_addr),
    .byte1_i (item_i.rx_status),
    .byte2_i (item_i.rx_error),
    .crc_o   (rx_crc_calc)
  );

  // one step of the poll sequence
  always_comb begin
    cur_addr_d   = cur_addr_q;
    send_ready_d = send_ready_q;
    awaiting_d   = awaiting_q;
    wait_ticks_d = wait_ticks_q;
    retry_d      = retry_q;
    en_map_d     = en_map_q;
    fire_total_d = fire_total_q;
    received     = 1'b0;
    cur_en       = 1'b0;
    res          = '0;

    // event
    case (item_i.op)
      spm_pkg::OP_TICK: begin
        if (awaiting_q && wait_ticks_q != spm_pkg::CNT16_MAX) begin
          wait_ticks_d = wait_ticks_q + 16'd1;
        end
      end
      spm_pkg::OP_REPLY: begin
        received = 1'b1;
      end
      spm_pkg::OP_MAP_WR: begin
        if ({1'b0, item_i.table_addr} < SpaceLim) begin
          en_map_d[item_i.table_addr[IdxW-1:0]] = item_i.table_enable;
        end
      end
      default: begin
      end
    endcase

    // send
    if (send_ready_q) begin
      cur_addr_d = norm_addr;
      if ({1'b0, norm_addr} < SpaceLim) begin
        cur_en = en_map_d[norm_addr[IdxW-1:0]];
      end
      received = 1'b0;
      if (!cur_en) begin
        cur_addr_d = norm_addr + 8'd1;
      end else begin
        res.tx_valid = 1'b1;
        res.tx_addr  = norm_addr;
        res.tx_crc   = tx_crc;
        send_ready_d = 1'b0;
        awaiting_d   = 1'b1;
        wait_ticks_d = '0;
      end
    end

    // timeout
    if (awaiting_d && !received && wait_ticks_d > cfg_i.response_timeout) begin
      if (retry_d > cfg_i.max_retries) begin
        res.wire_fault_set = 1'b1;
        res.fault_addr     = cur_addr_d;
        retry_d            = '0;
        cur_addr_d         = cur_addr_d + 8'd1;
      end else begin
        res.abort_receive = 1'b1;
        if (retry_d != spm_pkg::RETRY_MAX) begin
          retry_d = retry_d + 4'd1;
        end
      end
      awaiting_d   = 1'b0;
      send_ready_d = 1'b1;
    end

    // reply check
    if (awaiting_d && received) begin
      if (rx_crc_calc == rx_crc) begin
        res.reply_ok = 1'b1;
        if (item_i.rx_status == 8'd0 && fire_total_q != spm_pkg::CNT16_MAX) begin
          fire_total_d = fire_total_q + 16'd1;
        end
      end else begin
        res.reply_crc_error = 1'b1;
      end
      cur_addr_d   = cur_addr_d + 8'd1;
      retry_d      = '0;
      awaiting_d   = 1'b0;
      send_ready_d = 1'b1;
    end

    res.fire_count = fire_total_d;
  end

  assign res_o = res;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_addr_q   <= spm_pkg::ADDR_FIRST;
      send_ready_q <= 1'b1;
      awaiting_q   <= 1'b0;
      wait_ticks_q <= '0;
      retry_q      <= '0;
      en_map_q     <= '0;
      fire_total_q <= '0;
    end else if (step_i) begin
      cur_addr_q   <= cur_addr_d;
      send_ready_q <= send_ready_d;
      awaiting_q   <= awaiting_d;
      wait_ticks_q <= wait_ticks_d;
      retry_q      <= retry_d;
      en_map_q     <= en_map_d;
      fire_total_q <= fire_total_d;
    end
  end

endmodule

// ===== sim/sensor_poll_master_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor_poll_master_core_tb
// Self-checking bench for the sensor poll master. A queue-fed driver offers
// ticks, reply frames and enable map writes; an item-level poll model predicts
// every result, and a monitor compares each result transfer field by field.
// ----------------------------------------------------------------------------
module sensor_poll_master_core_tb;

  // op value with no event attached
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam int HOLD_AT     = 60;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE      = 6;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = '0;
  logic [7:0]  rx_addr_i = '0;
  logic [7:0]  rx_status_i = '0;
  logic [7:0]  rx_error_i = '0;
  logic [7:0]  rx_crc_low_i = '0;
  logic [7:0]  rx_crc_high_i = '0;
  logic [7:0]  table_addr_i = '0;
  logic        table_enable_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        tx_valid_o;
  logic [7:0]  tx_addr_o;
  logic [15:0] tx_crc_o;
  logic        abort_receive_o;
  logic        wire_fault_set_o;
  logic [7:0]  fault_addr_o;
  logic        reply_ok_o;
  logic        reply_crc_error_o;
  logic [15:0] fire_count_o;

  sensor_poll_master_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .rx_addr_i        (rx_addr_i),
    .rx_status_i      (rx_status_i),
    .rx_error_i       (rx_error_i),
    .rx_crc_low_i     (rx_crc_low_i),
    .rx_crc_high_i    (rx_crc_high_i),
    .table_addr_i     (table_addr_i),
    .table_enable_i   (table_enable_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .tx_valid_o       (tx_valid_o),
    .tx_addr_o        (tx_addr_o),
    .tx_crc_o         (tx_crc_o),
    .abort_receive_o  (abort_receive_o),
    .wire_fault_set_o (wire_fault_set_o),
    .fault_addr_o     (fault_addr_o),
    .reply_ok_o       (reply_ok_o),
    .reply_crc_error_o(reply_crc_error_o),
    .fire_count_o     (fire_count_o)
  );

  // poll model state and its copy of the registers
  logic [15:0]  tmo_cfg    = spm_pkg::TIMEOUT_RST;
  logic [3:0]   retry_cfg  = spm_pkg::RETRIES_RST;
  logic [7:0]   cur_addr   = spm_pkg::ADDR_FIRST;
  logic         send_rdy   = 1'b1;
  logic         awaiting   = 1'b0;
  logic [15:0]  wait_cnt   = '0;
  logic [3:0]   retry_cnt  = '0;
  logic [255:0] en_map     = '0;
  logic [15:0]  fire_total = '0;

  spm_pkg::item_t   poll_events_q[$];
  spm_pkg::result_t poll_results_q[$];
  spm_pkg::item_t   cur_event;

  // pacing knobs set per phase
  int unsigned gap_pct   = 25;
  int unsigned stall_pct = 25;
  bit          quiet     = 1'b0;

  int gap_left;
  int stall_left;
  int hold_left;
  bit hold_done;
  int results_seen;
  int mismatches;

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // crc-16 over three bytes, reflected, fed lsb first
  function automatic logic [15:0] modbus_crc3(logic [7:0] b0, logic [7:0] b1,
                                              logic [7:0] b2);
    logic [15:0] crc;
    logic [23:0] msg;
    crc = spm_pkg::CRC_INIT;
    msg = {b2, b1, b0};
    for (int i = 0; i < 24; i++) begin
      crc = crc ^ {15'd0, msg[i]};
      crc = crc[0] ? ((crc >> 1) ^ spm_pkg::CRC_POLY) : (crc >> 1);
    end
    return crc;
  endfunction

  // one step of the poll master: event, then send, timeout and reply stages
  function automatic spm_pkg::result_t poll_master_step(spm_pkg::item_t ev);
    spm_pkg::result_t r;
    logic             got_reply;
    r = '0;
    got_reply = (ev.op == spm_pkg::OP_REPLY);
    if (ev.op == spm_pkg::OP_TICK && awaiting && wait_cnt != spm_pkg::CNT16_MAX) wait_cnt++;
    if (ev.op == spm_pkg::OP_MAP_WR) en_map[ev.table_addr] = ev.table_enable;

    // send stage
    if (send_rdy) begin
      if (cur_addr < spm_pkg::ADDR_FIRST || cur_addr > spm_pkg::ADDR_LAST)
        cur_addr = spm_pkg::ADDR_FIRST;
      got_reply = 1'b0;
      if (!en_map[cur_addr]) begin
        cur_addr++;
      end else begin
        r.tx_valid = 1'b1;
        r.tx_addr  = cur_addr;
        r.tx_crc   = modbus_crc3(cur_addr, spm_pkg::REQ_FUNC, spm_pkg::REQ_DATA);
        send_rdy   = 1'b0;
        awaiting   = 1'b1;
        wait_cnt   = '0;
      end
    end

    // timeout stage
    if (awaiting && !got_reply && wait_cnt > tmo_cfg) begin
      if (retry_cnt > retry_cfg) begin
        r.wire_fault_set   = 1'b1;
        r.fault_addr       = cur_addr;
        retry_cnt          = '0;
        cur_addr++;
      end else begin
        r.abort_receive = 1'b1;
        if (retry_cnt != spm_pkg::RETRY_MAX) retry_cnt++;
      end
      awaiting = 1'b0;
      send_rdy = 1'b1;
    end

    // reply stage
    if (awaiting && got_reply) begin
      if (modbus_crc3(ev.rx_addr, ev.rx_status, ev.rx_error) ==
          {ev.rx_crc_high, ev.rx_crc_low}) begin
        r.reply_ok = 1'b1;
        if (ev.rx_status == 8'd0) begin
          if (fire_total != spm_pkg::CNT16_MAX) fire_total++;
        end
      end else begin
        r.reply_crc_error = 1'b1;
      end
      cur_addr++;
      retry_cnt = '0;
      awaiting  = 1'b0;
      send_rdy  = 1'b1;
    end

    r.fire_count = fire_total;
    return r;
  endfunction

  function automatic spm_pkg::item_t mk_event(logic [1:0] op, logic [7:0] addr,
                                              logic [7:0] status, logic [7:0] err,
                                              logic [15:0] crc, logic [7:0] taddr,
                                              logic ten);
    spm_pkg::item_t e;
    e.op           = op;
    e.rx_addr      = addr;
    e.rx_status    = status;
    e.rx_error     = err;
    e.rx_crc_low   = crc[7:0];
    e.rx_crc_high  = crc[15:8];
    e.table_addr   = taddr;
    e.table_enable = ten;
    return e;
  endfunction

  // random event; replies mostly carry a good crc, many of them alarms
  function automatic spm_pkg::item_t rand_event(int unsigned tick_pct);
    spm_pkg::item_t e;
    int unsigned    pick;
    e.rx_addr      = 8'($urandom_range(255));
    e.rx_status    = 8'($urandom_range(255));
    e.rx_error     = 8'($urandom_range(255));
    e.rx_crc_low   = 8'($urandom_range(255));
    e.rx_crc_high  = 8'($urandom_range(255));
    e.table_addr   = 8'($urandom_range(255));
    e.table_enable = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < tick_pct) begin
      e.op = spm_pkg::OP_TICK;
    end else begin
      pick = $urandom_range(99);
      if (pick < 55)      e.op = spm_pkg::OP_REPLY;
      else if (pick < 90) e.op = spm_pkg::OP_MAP_WR;
      else                e.op = OP_NONE;
    end
    if (e.op == spm_pkg::OP_REPLY) begin
      if ($urandom_range(99) < 40) e.rx_status = 8'd0;
      if ($urandom_range(99) < 70)
        {e.rx_crc_high, e.rx_crc_low} = modbus_crc3(e.rx_addr, e.rx_status, e.rx_error);
    end
    if (e.op == spm_pkg::OP_MAP_WR) e.table_enable = ($urandom_range(99) < 70);
    return e;
  endfunction

  // wait until every item is taken and every result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    while (poll_events_q.size() != 0 || in_valid_i || poll_results_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // register write while idle; upper data bits of a retry limit write are random noise
  task automatic write_reg(logic idx, logic [15:0] val);
    logic [15:0] data;
    data = (idx == spm_pkg::CFG_MAX_RETRIES) ? {16'($urandom_range(16'hFFFF))} : val;
    if (idx == spm_pkg::CFG_MAX_RETRIES) data[3:0] = val[3:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == spm_pkg::CFG_RESPONSE_TIMEOUT) tmo_cfg = data;
    else retry_cfg = data[3:0];
  endtask

  task automatic run_phase(int n, int unsigned tick_pct);
    for (int i = 0; i < n; i++) poll_events_q.push_back(rand_event(tick_pct));
    wait_drained();
  endtask

  // stimulus
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, every op, replies in and out of a wait
    poll_events_q.push_back(mk_event(OP_NONE, 8'h00, 8'h00, 8'h00, 16'h0000, 8'd0, 1'b0));
    poll_events_q.push_back(mk_event(spm_pkg::OP_MAP_WR, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF,
                                     8'd0, 1'b1));
    poll_events_q.push_back(mk_event(spm_pkg::OP_MAP_WR, 8'h00, 8'h00, 8'h00, 16'h0000,
                                     8'd255, 1'b1));
    poll_events_q.push_back(mk_event(spm_pkg::OP_MAP_WR, 8'h00, 8'h00, 8'h00, 16'h0000,
                                     8'd254, 1'b1));
    poll_events_q.push_back(mk_event(spm_pkg::OP_REPLY, 8'd9, 8'h00, 8'h00,
                                     modbus_crc3(8'd9, 8'h00, 8'h00), 8'd0, 1'b0));
    poll_events_q.push_back(mk_event(spm_pkg::OP_MAP_WR, 8'h00, 8'h00, 8'h00, 16'h0000,
                                     8'd7, 1'b1));
    poll_events_q.push_back(mk_event(spm_pkg::OP_MAP_WR, 8'h00, 8'h00, 8'h00, 16'h0000,
                                     8'd8, 1'b1));
    poll_events_q.push_back(mk_event(spm_pkg::OP_REPLY, 8'd8, 8'h00, 8'h00,
                                     modbus_crc3(8'd8, 8'h00, 8'h00), 8'd0, 1'b0));
    poll_events_q.push_back(mk_event(spm_pkg::OP_TICK, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF,
                                     8'd255, 1'b1));
    poll_events_q.push_back(mk_event(spm_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 16'h0000,
                                     8'd0, 1'b0));
    poll_events_q.push_back(mk_event(spm_pkg::OP_REPLY, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF,
                                     8'd0, 1'b0));
    poll_events_q.push_back(mk_event(OP_NONE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'd255, 1'b1));
    poll_events_q.push_back(mk_event(spm_pkg::OP_REPLY, 8'd0, 8'd0, 8'd0,
                                     modbus_crc3(8'd0, 8'd0, 8'd0), 8'd0, 1'b0));
    poll_events_q.push_back(mk_event(OP_NONE, 8'h00, 8'h00, 8'h00, 16'h0000, 8'd0, 1'b0));
    poll_events_q.push_back(mk_event(spm_pkg::OP_REPLY, 8'd254, 8'h5A, 8'hFF,
                                     modbus_crc3(8'd254, 8'h5A, 8'hFF), 8'd0, 1'b0));
    poll_events_q.push_back(mk_event(spm_pkg::OP_MAP_WR, 8'h00, 8'h00, 8'h00, 16'h0000,
                                     8'd9, 1'b1));
    poll_events_q.push_back(mk_event(spm_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 16'h0000,
                                     8'd0, 1'b0));
    poll_events_q.push_back(mk_event(spm_pkg::OP_REPLY, 8'd255, 8'h00, 8'h01,
                                     modbus_crc3(8'd255, 8'h00, 8'h01) ^ 16'h8000,
                                     8'd0, 1'b0));
    poll_events_q.push_back(mk_event(spm_pkg::OP_MAP_WR, 8'h00, 8'h00, 8'h00, 16'h0000,
                                     8'd7, 1'b0));
    poll_events_q.push_back(mk_event(spm_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 16'h0000,
                                     8'd0, 1'b0));
    wait_drained();

    // shortest timeout, retry limit zero: faults come quickly
    write_reg(spm_pkg::CFG_RESPONSE_TIMEOUT, 16'd0);
    write_reg(spm_pkg::CFG_MAX_RETRIES, 16'd0);
    run_phase(150, 50);

    // longest timeout: a long wait that never times out
    gap_pct   = 0;
    stall_pct = 0;
    write_reg(spm_pkg::CFG_RESPONSE_TIMEOUT, 16'hFFFF);
    write_reg(spm_pkg::CFG_MAX_RETRIES, 16'd15);
    for (int a = 0; a < 256; a += 32)
      poll_events_q.push_back(mk_event(spm_pkg::OP_MAP_WR, 8'h00, 8'h00, 8'h00, 16'h0000,
                                       8'(a), 1'b1));
    for (int t = 0; t < 40; t++)
      poll_events_q.push_back(mk_event(spm_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 16'h0000,
                                       8'd0, 1'b0));
    poll_events_q.push_back(mk_event(spm_pkg::OP_REPLY, 8'd42, 8'd0, 8'd3,
                                     modbus_crc3(8'd42, 8'd0, 8'd3), 8'd0, 1'b0));
    wait_drained();

    // short random timeouts and retry limits
    gap_pct   = 25;
    stall_pct = 25;
    write_reg(spm_pkg::CFG_RESPONSE_TIMEOUT, 16'($urandom_range(1, 8)));
    write_reg(spm_pkg::CFG_MAX_RETRIES, 16'($urandom_range(0, 4)));
    run_phase(200, 55);

    // most retries, tick heavy so the retry count saturates
    gap_pct   = 10;
    stall_pct = 40;
    write_reg(spm_pkg::CFG_RESPONSE_TIMEOUT, 16'd2);
    write_reg(spm_pkg::CFG_MAX_RETRIES, 16'd15);
    run_phase(150, 80);

    // closing stretch at full rate
    quiet = 1'b1;
    write_reg(spm_pkg::CFG_RESPONSE_TIMEOUT, 16'd3);
    write_reg(spm_pkg::CFG_MAX_RETRIES, 16'd1);
    run_phase(250, 55);

    if (poll_results_q.size() != 0) mismatches += poll_results_q.size();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // driver: offer queued events, hold each until its transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else if (!(in_valid_i && !in_ready_o)) begin
      if (in_valid_i) poll_results_q.push_back(poll_master_step(cur_event));
      if (gap_left != 0 && !quiet) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (poll_events_q.size() != 0 && !quiet && $urandom_range(99) < gap_pct) begin
        gap_left = $urandom_range(15);
        in_valid_i <= 1'b0;
      end else if (poll_events_q.size() != 0) begin
        cur_event = poll_events_q.pop_front();
        op_i           <= cur_event.op;
        rx_addr_i      <= cur_event.rx_addr;
        rx_status_i    <= cur_event.rx_status;
        rx_error_i     <= cur_event.rx_error;
        rx_crc_low_i   <= cur_event.rx_crc_low;
        rx_crc_high_i  <= cur_event.rx_crc_high;
        table_addr_i   <= cur_event.table_addr;
        table_enable_i <= cur_event.table_enable;
        in_valid_i     <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d %s: expected %0h, got %0h", results_seen, name, want, got);
    end
  endtask

  // monitor: compare each result transfer, pace the ready side
  always @(posedge clk_i or negedge rst_ni) begin
    spm_pkg::result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (poll_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result %0d arrived with none pending", results_seen);
        end else begin
          want = poll_results_q.pop_front();
          check_field("tx_valid", 16'(want.tx_valid), 16'(tx_valid_o));
          check_field("tx_addr", 16'(want.tx_addr), 16'(tx_addr_o));
          check_field("tx_crc", want.tx_crc, tx_crc_o);
          check_field("abort_receive", 16'(want.abort_receive), 16'(abort_receive_o));
          check_field("wire_fault_set", 16'(want.wire_fault_set), 16'(wire_fault_set_o));
          check_field("fault_addr", 16'(want.fault_addr), 16'(fault_addr_o));
          check_field("reply_ok", 16'(want.reply_ok), 16'(reply_ok_o));
          check_field("reply_crc_error", 16'(want.reply_crc_error), 16'(reply_crc_error_o));
          check_field("fire_count", want.fire_count, fire_count_o);
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else if (stall_left != 0 && !quiet) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(15);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

endmodule

// ===== sim.f =====
src/spm_pkg.sv
src/spm_crc3.sv
src/spm_ctrl.sv
src/sensor_poll_master_core.sv
sim/sensor_poll_master_core_tb.sv
